// File: hw/rtl/html_stream_tokenizer_defines.svh
// Assertion macros for the HTML stream tokenizer.
// No dependencies; included by the files that assert.
`ifndef HTML_STREAM_TOKENIZER_DEFINES_SVH
`define HTML_STREAM_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define HST_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define HST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HST_ASSERT(name, clk, rst, prop)
`define HST_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/hst_pkg.sv
// Shared types, constants and functions of the HTML stream tokenizer.
// No dependencies.
package hst_pkg;

   localparam int unsigned MAX_PARTS     = 16;
   localparam int unsigned SEGMENT_CHARS = 1024;
   localparam int unsigned ENTITY_MAX    = 15;
   localparam int unsigned QDEPTH        = 4;

   localparam logic [8:0] CL_WS = 9'd256;
   localparam logic [8:0] CL_LT = 9'd257;
   localparam logic [8:0] CL_GT = 9'd258;

   localparam logic [1:0] K_STRING  = 2'd0;
   localparam logic [1:0] K_TAG     = 2'd1;
   localparam logic [1:0] K_COMMENT = 2'd2;
   localparam logic [1:0] K_END     = 2'd3;

   typedef enum logic [5:0] {
      M_IDLE    = 6'b000001,
      M_SCONT   = 6'b000010,
      M_TFIRST  = 6'b000100,
      M_TAG     = 6'b001000,
      M_COMMENT = 6'b010000,
      M_STRING  = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] kind;
      logic       tstart;
      logic       tend;
      logic       ps;
      logic [3:0] pi;
      logic       vs;
      logic       sep;
   } res_type;

   typedef struct packed {
      logic [1:0] cnt;
      res_type    r1;
      res_type    r0;
   } pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [2:0] ent_len(input logic [1:0] i);
      case (i)
         2'd0:    ent_len = 3'd4;
         2'd1:    ent_len = 3'd3;
         default: ent_len = 3'd2;
      endcase
   endfunction

   function automatic logic [7:0] ent_char(input logic [1:0] i);
      case (i)
         2'd0:    ent_char = 8'h20;
         2'd1:    ent_char = 8'h26;
         2'd2:    ent_char = 8'h3e;
         default: ent_char = 8'h3c;
      endcase
   endfunction

   function automatic logic [7:0] ent_name(input logic [1:0] i, input logic [1:0] j);
      logic [31:0] w;
      case (i)
         2'd0:    w = {"p", "s", "b", "n"};
         2'd1:    w = {8'h00, "p", "m", "a"};
         2'd2:    w = {16'h0000, "t", "g"};
         default: w = {16'h0000, "t", "l"};
      endcase
      ent_name = w[j*8 +: 8];
   endfunction

   function automatic res_type mk(input logic [7:0] ch, input logic [1:0] kind,
                                  input logic tstart, input logic tend, input logic ps,
                                  input logic [3:0] pi, input logic vs, input logic sep);
      res_type r;
      r.ch = ch; r.kind = kind; r.tstart = tstart; r.tend = tend;
      r.ps = ps; r.pi = pi; r.vs = vs; r.sep = sep;
      mk = r;
   endfunction

endpackage

// File: hw/rtl/hst_front.sv
// Front end: byte classification, entity decode and token state.
// Builds up to two results per transaction. Uses hst_pkg.
module hst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              acc,
   input  logic [7:0]        in_byte,
   input  logic              end_of_input,
   output hst_pkg::pair_type pair
);
   import hst_pkg::*;

   typedef struct packed {
      mode_type    mode;
      logic        ent_act;
      logic [3:0]  ent_len;
      logic [3:0]  cand;
      logic [8:0]  prev;
      logic [4:0]  parts;
      logic [10:0] seg;
      logic [1:0]  skip;
      logic        cut;
   } st_type;

   typedef struct packed {
      st_type   s;
      pair_type p;
   } fr_type;

   localparam st_type RESET_ST = '{mode: M_IDLE, ent_act: 1'b0, ent_len: 4'd0,
      cand: 4'hf, prev: CL_WS, parts: 5'd0, seg: 11'd0, skip: 2'd0, cut: 1'b0};

   function automatic pair_type put(input pair_type p, input res_type x);
      pair_type q;
      q = p;
      if (p.cnt == 2'd0) begin
         q.r0 = x; q.cnt = 2'd1;
      end else if (p.cnt == 2'd1) begin
         q.r1 = x; q.cnt = 2'd2;
      end
      put = q;
   endfunction

   function automatic logic [7:0] shown(input logic [8:0] c);
      if (c == CL_WS) shown = 8'h20;
      else if (c == CL_LT) shown = 8'h3c;
      else if (c == CL_GT) shown = 8'h3e;
      else shown = c[7:0];
   endfunction

   function automatic logic [10:0] cnt_up(input logic [10:0] v);
      cnt_up = (v != 11'h7ff) ? v + 11'd1 : v;
   endfunction

   function automatic fr_type string_char(input fr_type f, input logic [8:0] c);
      fr_type g;
      g = f;
      g.p = put(g.p, mk(shown(c), K_STRING, g.s.seg == 11'd0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0));
      g.s.seg = cnt_up(g.s.seg);
      if (g.s.seg >= 11'(SEGMENT_CHARS)) begin
         g.p = put(g.p, mk(8'd0, K_STRING, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0));
         g.s.mode = M_SCONT;
      end
      string_char = g;
   endfunction

   function automatic fr_type tag_char(input fr_type f, input logic [8:0] c);
      fr_type g;
      logic ps, vs, sep;
      logic [3:0] pi;
      g = f; ps = 1'b0; vs = 1'b0;
      if (c == CL_GT) begin
         g.p = put(g.p, mk(8'd0, K_TAG, g.s.seg == 11'd0, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0));
         g.s.mode = M_IDLE;
      end else begin
         if (g.s.prev == CL_WS && c != CL_WS) begin
            if (g.s.parts < 5'(MAX_PARTS)) begin
               ps = 1'b1; g.s.parts = g.s.parts + 5'd1;
            end
         end else if (g.s.prev == 9'h03d && c != CL_WS) begin
            vs = (g.s.parts != 5'd0);
         end
         pi = (g.s.parts != 5'd0) ? 4'(g.s.parts - 5'd1) : 4'd0;
         sep = (c == CL_WS) || (c == 9'h03d);
         g.p = put(g.p, mk(shown(c), K_TAG, g.s.seg == 11'd0, 1'b0, ps, pi, vs, sep));
         g.s.seg = cnt_up(g.s.seg);
         g.s.prev = c;
      end
      tag_char = g;
   endfunction

   function automatic fr_type comment_char(input fr_type f, input logic [8:0] c);
      fr_type g;
      logic held;
      g = f;
      held = !g.s.cut && g.s.prev == 9'h02d;
      if (g.s.skip != 2'd0) begin
         g.s.skip = g.s.skip - 2'd1;
      end else if (c == CL_GT) begin
         if (held) begin
            g.p = put(g.p, mk(8'h2d, K_COMMENT, g.s.seg == 11'd0, 1'b0, 1'b0, 4'd0, 1'b0,
                              1'b0));
            g.s.seg = cnt_up(g.s.seg);
         end
         g.p = put(g.p, mk(8'd0, K_COMMENT, g.s.seg == 11'd0, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0));
         g.s.mode = M_IDLE;
      end else if (g.s.cut) begin
         g.s.cut = 1'b1;
      end else if (held && c == 9'h02d) begin
         g.s.cut = 1'b1;
      end else begin
         if (held) begin
            g.p = put(g.p, mk(8'h2d, K_COMMENT, g.s.seg == 11'd0, 1'b0, 1'b0, 4'd0, 1'b0,
                              1'b0));
            g.s.seg = cnt_up(g.s.seg);
         end
         if (c != 9'h02d) begin
            g.p = put(g.p, mk(shown(c), K_COMMENT, g.s.seg == 11'd0, 1'b0, 1'b0, 4'd0, 1'b0,
                              1'b0));
            g.s.seg = cnt_up(g.s.seg);
         end
         g.s.prev = c;
      end
      comment_char = g;
   endfunction

   function automatic fr_type feed(input fr_type f, input logic [8:0] c);
      fr_type g;
      g = f;
      case (g.s.mode)
         M_STRING: begin
            if (c == CL_LT) begin
               g.p = put(g.p, mk(8'd0, K_STRING, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0));
               g.s.mode = M_TFIRST;
            end else begin
               g = string_char(g, c);
            end
         end
         M_TFIRST: begin
            g.s.seg = 11'd0; g.s.prev = CL_WS; g.s.parts = 5'd0; g.s.cut = 1'b0;
            if (c == 9'h021) begin
               g.s.mode = M_COMMENT; g.s.skip = 2'd2;
            end else begin
               g.s.mode = M_TAG;
               g = tag_char(g, c);
            end
         end
         M_TAG:     g = tag_char(g, c);
         M_COMMENT: g = comment_char(g, c);
         default: begin
            if (c == CL_WS && g.s.mode != M_SCONT) begin
               g.s.mode = g.s.mode;
            end else if (c == CL_LT) begin
               g.s.mode = M_TFIRST;
            end else begin
               g.s.mode = M_STRING; g.s.seg = 11'd0;
               g = string_char(g, c);
            end
         end
      endcase
      feed = g;
   endfunction

   st_type st_ff, st_in;
   fr_type f;
   logic [8:0] c;
   logic       do_feed;

   always_comb begin
      f.s = st_ff;
      f.p = '0;
      c = {1'b0, in_byte};
      do_feed = 1'b0;
      if (end_of_input) begin
         if (st_ff.mode == M_COMMENT && st_ff.skip == 2'd0 && !st_ff.cut &&
             st_ff.prev == 9'h02d)
            f.p = put(f.p, mk(8'h2d, K_COMMENT, st_ff.seg == 11'd0, 1'b0, 1'b0, 4'd0, 1'b0,
                              1'b0));
         f.p = put(f.p, mk(8'd0, K_END, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0));
         f.s = RESET_ST;
      end else if (st_ff.ent_act) begin
         if (in_byte == 8'h3b) begin
            c = 9'h03b;
            for (int i = 0; i < 4; i++)
               if (st_ff.cand[i] && st_ff.ent_len == {1'b0, ent_len(2'(i))})
                  c = {1'b0, ent_char(2'(i))};
            f.s.ent_act = 1'b0; f.s.ent_len = 4'd0; f.s.cand = 4'hf;
            do_feed = 1'b1;
         end else begin
            for (int i = 0; i < 4; i++)
               if (st_ff.ent_len >= {1'b0, ent_len(2'(i))} ||
                   ent_name(2'(i), st_ff.ent_len[1:0]) != in_byte)
                  f.s.cand[i] = 1'b0;
            if (st_ff.ent_len < 4'(ENTITY_MAX)) f.s.ent_len = st_ff.ent_len + 4'd1;
         end
      end else begin
         do_feed = 1'b1;
         case (in_byte)
            8'h20, 8'h0a, 8'h09, 8'h0d: c = CL_WS;
            8'h3c: c = CL_LT;
            8'h3e: c = CL_GT;
            8'h26: begin
               do_feed = 1'b0;
               f.s.ent_act = 1'b1; f.s.ent_len = 4'd0; f.s.cand = 4'hf;
            end
            default: c = {1'b0, in_byte};
         endcase
      end
      if (do_feed) f = feed(f, c);
      st_in = f.s;
      pair = f.p;
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= RESET_ST;
      else if (acc) st_ff <= st_in;
   end

endmodule

// File: hw/rtl/hst_queue.sv
// Four-entry queue of result pairs between front and back end.
// Uses hst_pkg and the assertion macros.
`include "html_stream_tokenizer_defines.svh"
module hst_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hst_pkg::pair_type  wdata,
   input  logic               pop,
   output hst_pkg::pair_type  rdata,
   output hst_pkg::qstat_type stat
);
   import hst_pkg::*;

   localparam int unsigned AW = $clog2(QDEPTH);

   pair_type          mem_ff [QDEPTH];
   logic [AW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]       cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == (AW+1)'(QDEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign rdata      = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wdata;
   end

   `HST_ASSERT(a_cnt_max, clock, reset, cnt_ff <= (AW+1)'(QDEPTH))
   `HST_ASSERT(a_no_over, clock, reset, !(push && stat.full))
   `HST_ASSERT(a_no_under, clock, reset, !(pop && stat.empty))
   `HST_ASSERT_NEXT(a_push_grow, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1)

endmodule

// File: hw/rtl/hst_back.sv
// Back end: sends the one or two results of each queue entry in order.
// Uses hst_pkg.
module hst_back (
   input  logic              clock,
   input  logic              reset,
   input  hst_pkg::pair_type head,
   input  logic              avail,
   input  logic              rsp_stall,
   output logic              pop,
   output logic              rsp_valid,
   output hst_pkg::res_type  rsp,
   output logic              rsp_last
);
   import hst_pkg::*;

   logic idx_ff, idx_in;
   logic fire;

   assign rsp_valid = avail;
   assign rsp       = idx_ff ? head.r1 : head.r0;
   assign rsp_last  = idx_ff || (head.cnt == 2'd1);
   assign fire      = avail && !rsp_stall;
   assign pop       = fire && rsp_last;

   always_comb begin
      idx_in = idx_ff;
      if (fire) idx_in = !rsp_last;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 1'b0;
      else idx_ff <= idx_in;
   end

endmodule

// File: hw/rtl/html_stream_tokenizer.sv
// HTML stream tokenizer: accepts one byte transaction per cycle while the queue has room.
// Results are registered in the queue and read from its head; they leave one per cycle
// while rsp_stall is low, the results of each transaction in order.
// A four-entry queue decouples the front end from output stalls.
// Synchronous active-high reset returns the tokenizer to between-tokens state
// and empties the queue. Uses hst_pkg, hst_front, hst_queue, hst_back.
module html_stream_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_token_kind,
   output logic       rsp_token_start,
   output logic       rsp_token_end,
   output logic       rsp_part_start,
   output logic [3:0] rsp_part_index,
   output logic       rsp_value_start,
   output logic       rsp_separator,
   output logic       rsp_last
);
   import hst_pkg::*;

   pair_type  fpair, qhead;
   qstat_type qstat;
   res_type   r;
   logic      acc, push, pop;

   assign req_stall = qstat.full;
   assign acc       = req_valid && !qstat.full;
   assign push      = acc && (fpair.cnt != 2'd0);

   hst_front u_front (
      .clock(clock), .reset(reset), .acc(acc), .in_byte(req_in_byte),
      .end_of_input(req_end_of_input), .pair(fpair)
   );

   hst_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .wdata(fpair), .pop(pop),
      .rdata(qhead), .stat(qstat)
   );

   hst_back u_back (
      .clock(clock), .reset(reset), .head(qhead), .avail(!qstat.empty),
      .rsp_stall(rsp_stall), .pop(pop), .rsp_valid(rsp_valid), .rsp(r),
      .rsp_last(rsp_last)
   );

   assign rsp_out_char    = r.ch;
   assign rsp_token_kind  = r.kind;
   assign rsp_token_start = r.tstart;
   assign rsp_token_end   = r.tend;
   assign rsp_part_start  = r.ps;
   assign rsp_part_index  = r.pi;
   assign rsp_value_start = r.vs;
   assign rsp_separator   = r.sep;

endmodule
